// ----- rtl/clr_pkg.sv -----
// Shared types and codes for the circular linked ring block.
// No dependencies; every other file in rtl/ imports this package.
package clr_pkg;

   localparam int OPCODE_W    = 2;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int ELEM_COUNT_W = 7;

   // operation codes
   localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

   typedef logic [OPCODE_W-1:0]       opcode_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [STATUS_W-1:0]       status_type;
   typedef logic [ELEM_COUNT_W-1:0]   elem_count_type;

   // write enables into the node memories
   typedef struct packed {
      logic val_we;
      logic link_we;
   } node_wr_type;

   // commands into the free index stack
   typedef struct packed {
      logic pop;
      logic push;
   } free_ctl_type;

endpackage

// ----- rtl/clr_if.sv -----
// Valid/ready channel interfaces for the request, response and CSR channels.
// Depends on clr_pkg for payload types.
interface clr_req_if;
   import clr_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   value_type  value;
   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface clr_rsp_if;
   import clr_pkg::*;
   logic           valid;
   logic           ready;
   status_type     status;
   value_type      read_value;
   elem_count_type element_count;
   modport source (output valid, output status, output read_value,
                   output element_count, input ready);
   modport sink   (input valid, input status, input read_value,
                   input element_count, output ready);
endinterface

interface clr_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/clr_node_mem.sv -----
// Node pool storage: value memory and link memory, one read and one write
// port each, registered read data. Depends on clr_pkg.
module clr_node_mem #(
   parameter int DEPTH = 64,
   parameter int IW    = 6
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [IW-1:0]        rd_addr,
   output clr_pkg::value_type   val_q,
   output logic [IW-1:0]        link_q,
   input  clr_pkg::node_wr_type wr,
   input  logic [IW-1:0]        val_waddr,
   input  clr_pkg::value_type   val_wdata,
   input  logic [IW-1:0]        link_waddr,
   input  logic [IW-1:0]        link_wdata
);
   import clr_pkg::*;

   value_type   val_mem [DEPTH];
   logic [IW-1:0] link_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      if (rd_en) begin
         val_q <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (rd_en) begin
         link_q <= link_mem[rd_addr];
      end
   end

endmodule

// ----- rtl/clr_free_stack.sv -----
// Free node index stack in a memory, with a low-water mark standing in for
// the reset contents (position p holds p until first written). Depends on clr_pkg.
module clr_free_stack #(
   parameter int DEPTH = 64,
   parameter int IW    = 6,
   parameter int CW    = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  clr_pkg::free_ctl_type ctl,
   input  logic [IW-1:0]         push_idx,
   output logic [IW-1:0]         free_idx,
   output logic                  no_free
);
   import clr_pkg::*;

   logic [IW-1:0] stack_mem [DEPTH];
   logic [CW-1:0] top_ff;
   logic [CW-1:0] mark_ff;
   logic [CW-1:0] top_dec;
   logic [IW-1:0] rd_pos;
   logic [IW-1:0] rd_pos_ff;
   logic [IW-1:0] rd_data_ff;
   logic          fresh_ff;
   logic          can_push;

   assign top_dec  = top_ff - CW'(1);
   assign rd_pos   = IW'(top_dec);
   assign can_push = top_ff < CW'(DEPTH);
   assign no_free  = top_ff == '0;
   // never-written positions read as their own index
   assign free_idx = fresh_ff ? rd_pos_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff  <= CW'(DEPTH);
         mark_ff <= CW'(DEPTH);
      end else if (ctl.pop) begin
         top_ff <= top_dec;
         if (top_dec < mark_ff) begin
            mark_ff <= top_dec;
         end
      end else if (ctl.push && can_push) begin
         top_ff <= top_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && can_push) begin
         stack_mem[IW'(top_ff)] <= push_idx;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_pos];
         rd_pos_ff  <= rd_pos;
         fresh_ff   <= top_ff <= mark_ff;
      end
   end

endmodule

// ----- rtl/circular_linked_ring.sv -----
// Circular linked ring top level: sequencer, cursor registers, result register.
// Depends on clr_pkg, clr_if, clr_node_mem and clr_free_stack.
//
// Usage:
//   req_ch  (sink)   : one item = opcode + value. Opcodes: add after cursor,
//                      remove cursor node, advance cursor, read cursor value.
//   rsp_ch  (source) : one item per request = status, read_value and the
//                      element count after the operation.
//   csr_ch  (sink)   : one-bit positive_only mode; always ready. Write it
//                      only while no request is in flight.
// Timing: a request is taken in the idle state; its node and free-stack reads
//   come back registered in the execute state, where the result is loaded into
//   the response register and the memories are written. An add into a non-empty
//   ring goes on to the link state for the second link write. The response
//   register lets the next request start while a result waits to be taken.
// Stall: when the response register is still full at the end of an item,
//   the item holds in its execute cycle until the receiver takes the old one.
// Reset: synchronous, active high; empties the ring, refills the free
//   stack logically (no clearing pass), clears positive_only.
module circular_linked_ring #(
   parameter int POOL_DEPTH = 64
) (
   input logic   clock,
   input logic   reset,
   clr_req_if.sink   req_ch,
   clr_rsp_if.source rsp_ch,
   clr_csr_if.sink   csr_ch
);
   import clr_pkg::*;

   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LINK = 2'd2;

   logic [1:0]     state_ff, state_in;
   opcode_type     op_ff;
   value_type      value_ff;
   logic           positive_only_ff;
   logic [IW-1:0]  cursor_ff, cursor_in;
   logic [IW-1:0]  pred_ff, pred_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  new_node_ff, new_node_in;

   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff;
   value_type      rsp_value_ff;
   elem_count_type rsp_count_ff;

   logic           accept;
   logic           out_free;
   logic           fire;
   status_type     status;
   value_type      read_val;

   value_type      val_q;
   logic [IW-1:0]  link_q;
   node_wr_type    node_wr;
   logic [IW-1:0]  val_waddr;
   logic [IW-1:0]  link_waddr;
   logic [IW-1:0]  link_wdata;

   free_ctl_type   free_ctl;
   logic [IW-1:0]  free_idx;
   logic           no_free;

   logic           ring_empty;
   logic           ring_single;
   logic           ring_full;
   logic           nonpos;

   // Take a request only between items.
   assign req_ch.ready = state_ff == S_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;

   // Response register frees when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign fire     = (state_ff == S_EXEC) && out_free;

   assign csr_ch.ready = 1'b1;

   assign ring_empty  = count_ff == '0;
   assign ring_single = count_ff == CW'(1);
   assign ring_full   = no_free || (count_ff >= CW'(POOL_DEPTH));
   assign nonpos      = value_ff[VALUE_W-1] || (value_ff == '0);

   clr_node_mem #(.DEPTH(POOL_DEPTH), .IW(IW)) u_node_mem (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (cursor_ff),
      .val_q      (val_q),
      .link_q     (link_q),
      .wr         (node_wr),
      .val_waddr  (val_waddr),
      .val_wdata  (value_ff),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata)
   );

   clr_free_stack #(.DEPTH(POOL_DEPTH), .IW(IW), .CW(CW)) u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .ctl      (free_ctl),
      .push_idx (cursor_ff),
      .free_idx (free_idx),
      .no_free  (no_free)
   );

   // Execute: decode the captured item against the read data and the
   // cursor registers; in the execute state nothing moves until the result can be loaded.
   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      pred_in     = pred_ff;
      count_in    = count_ff;
      new_node_in = new_node_ff;
      status      = ST_OK;
      read_val    = '0;
      node_wr     = '0;
      free_ctl    = '0;
      val_waddr   = free_idx;
      link_waddr  = free_idx;
      link_wdata  = free_idx;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (fire) begin
               state_in = S_IDLE;
               case (op_ff)
                  OP_ADD: begin
                     if (positive_only_ff && nonpos) begin
                        status = ST_REJECT;
                     end else if (ring_full) begin
                        status = ST_FULL;
                     end else begin
                        // pop a node and store the value in it
                        free_ctl.pop   = 1'b1;
                        node_wr.val_we = 1'b1;
                        node_wr.link_we = 1'b1;
                        count_in       = count_ff + CW'(1);
                        if (ring_empty) begin
                           // first node links to itself
                           cursor_in = free_idx;
                           pred_in   = free_idx;
                        end else begin
                           // new node takes the cursor's old successor;
                           // relink the cursor next cycle
                           link_wdata  = link_q;
                           new_node_in = free_idx;
                           state_in    = S_LINK;
                           if (ring_single) begin
                              pred_in = free_idx;
                           end
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (ring_empty) begin
                        status = ST_EMPTY;
                     end else begin
                        free_ctl.push = 1'b1;
                        count_in      = count_ff - CW'(1);
                        if (ring_single) begin
                           cursor_in = '0;
                           pred_in   = '0;
                        end else begin
                           // splice the cursor node out, advance to successor
                           node_wr.link_we = 1'b1;
                           link_waddr      = pred_ff;
                           link_wdata      = link_q;
                           cursor_in       = link_q;
                        end
                     end
                  end
                  OP_ADVANCE: begin
                     if (ring_empty) begin
                        status = ST_EMPTY;
                     end else begin
                        pred_in   = cursor_ff;
                        cursor_in = link_q;
                     end
                  end
                  OP_READ: begin
                     if (ring_empty) begin
                        status = ST_EMPTY;
                     end else begin
                        read_val = val_q;
                     end
                  end
                  default: begin
                     status = ST_OK;
                  end
               endcase
            end
         end
         S_LINK: begin
            // second link write of an add: cursor now points at the new node
            node_wr.link_we = 1'b1;
            link_waddr      = cursor_ff;
            link_wdata      = new_node_ff;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         cursor_ff        <= '0;
         pred_ff          <= '0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         positive_only_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         pred_ff      <= pred_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            positive_only_ff <= csr_ch.data;
         end
      end
   end

   // Payload: capture the item, hold the new node, load the result.
   always_ff @(posedge clock) begin
      new_node_ff <= new_node_in;
      if (accept) begin
         op_ff    <= req_ch.opcode;
         value_ff <= req_ch.value;
      end
      if (fire) begin
         rsp_status_ff <= status;
         rsp_value_ff  <= read_val;
         rsp_count_ff  <= ELEM_COUNT_W'(count_in);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.read_value    = rsp_value_ff;
   assign rsp_ch.element_count = rsp_count_ff;

endmodule

// ----- rtl/clr_port_checker.sv -----
// Port-level checks for circular_linked_ring, attached by bind.
// Depends on clr_pkg and the circular_linked_ring top level.
module clr_port_checker #(
   parameter int POOL_DEPTH = 64
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input clr_pkg::status_type     rsp_status,
   input clr_pkg::value_type      rsp_read_value,
   input clr_pkg::elem_count_type rsp_element_count
);
   import clr_pkg::*;

   localparam int CHK_W = (ELEM_COUNT_W > 13) ? ELEM_COUNT_W : 13;

   // count never exceeds the pool (checked where the 7-bit count is exact)
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (POOL_DEPTH < 128)) |->
         (CHK_W'(rsp_element_count) <= CHK_W'(POOL_DEPTH)))
      else $error("element count beyond pool depth");

   // a full answer only comes with a full pool
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |->
         (rsp_element_count == ELEM_COUNT_W'(POOL_DEPTH)))
      else $error("full status with pool not full");

   // only a successful read carries a value; an empty answer means zero count
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
         ((rsp_read_value == '0) &&
          ((rsp_status != ST_EMPTY) || (rsp_element_count == '0))))
      else $error("value or count wrong on failed item");

   // one item at a time: no back-to-back request acceptance
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken in consecutive cycles");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) &&
          $stable(rsp_element_count)))
      else $error("response changed while stalled");

endmodule

bind circular_linked_ring clr_port_checker #(.POOL_DEPTH(POOL_DEPTH)) u_port_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_read_value    (rsp_ch.read_value),
   .rsp_element_count (rsp_ch.element_count)
);

// ----- tb/sv/clr_ring_checker.sv -----
`timescale 1ns / 100ps
// Checker for the circular linked ring: watches the request, response and CSR
// channels, tracks the ring in its own copy, and scores every response.
// Depends on clr_pkg and the channel interfaces in clr_if.
module clr_ring_checker #(
   parameter int POOL_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   clr_req_if   req_ch,
   clr_rsp_if   rsp_ch,
   clr_csr_if   csr_ch,
   output int   fault_count,
   output int   owed_count
);
   import clr_pkg::*;

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int SHOWN_FAULTS = 10;

   typedef logic [IDX_W-1:0] node_idx_type;

   typedef struct packed {
      status_type     status;
      value_type      read_value;
      elem_count_type element_count;
   } ring_reply_type;

   value_type      node_value [POOL_DEPTH];
   node_idx_type   node_next  [POOL_DEPTH];
   node_idx_type   free_idx   [POOL_DEPTH];
   int             free_top;
   int             live_count;
   node_idx_type   cursor;
   node_idx_type   cursor_prev;
   bit             positive_only;
   ring_reply_type owed_replies [$];

   function automatic void clear_ring();
      for (int i = 0; i < POOL_DEPTH; i++) begin
         node_value[i] = '0;
         node_next[i]  = '0;
         free_idx[i]   = node_idx_type'(i);
      end
      free_top      = POOL_DEPTH;
      live_count    = 0;
      cursor        = '0;
      cursor_prev   = '0;
      positive_only = 1'b0;
   endfunction

   // Apply one operation to the ring copy and return the response it owes.
   function automatic ring_reply_type apply_ring_op(input opcode_type op,
                                                    input value_type  val);
      ring_reply_type r;
      node_idx_type   n;
      node_idx_type   old;
      r.status     = ST_OK;
      r.read_value = '0;
      case (op)
         OP_ADD: begin
            if (positive_only && val <= 0) begin
               r.status = ST_REJECT;
            end else if (free_top == 0 || live_count >= POOL_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               free_top--;
               n = free_idx[free_top];
               node_value[n] = val;
               if (live_count == 0) begin
                  node_next[n] = n;
                  cursor       = n;
                  cursor_prev  = n;
               end else begin
                  node_next[n]      = node_next[cursor];
                  node_next[cursor] = n;
                  if (live_count == 1)
                     cursor_prev = n;
               end
               live_count++;
            end
         end
         OP_REMOVE: begin
            if (live_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               old = cursor;
               if (live_count == 1) begin
                  cursor      = '0;
                  cursor_prev = '0;
               end else begin
                  // unlink: predecessor now points past the removed node
                  node_next[cursor_prev] = node_next[old];
                  cursor = node_next[old];
               end
               if (free_top < POOL_DEPTH) begin
                  free_idx[free_top] = old;
                  free_top++;
               end
               live_count--;
            end
         end
         OP_ADVANCE: begin
            if (live_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               cursor_prev = cursor;
               cursor      = node_next[cursor];
            end
         end
         default: begin
            if (live_count == 0)
               r.status = ST_EMPTY;
            else
               r.read_value = node_value[cursor];
         end
      endcase
      r.element_count = elem_count_type'(live_count);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      ring_reply_type want;
      if (reset) begin
         clear_ring();
         owed_replies.delete();
         fault_count = 0;
      end else begin
         // score the response first so an item taken this edge cannot hide it
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_replies.size() == 0) begin
               if (fault_count < SHOWN_FAULTS)
                  $display("%0t: response with nothing owed: status %0d value %0d count %0d",
                           $realtime, rsp_ch.status, rsp_ch.read_value,
                           rsp_ch.element_count);
               fault_count++;
            end else begin
               want = owed_replies.pop_front();
               if (rsp_ch.status !== want.status ||
                   rsp_ch.read_value !== want.read_value ||
                   rsp_ch.element_count !== want.element_count) begin
                  if (fault_count < SHOWN_FAULTS)
                     $display("%0t: response mismatch: status exp %0d got %0d,",
                              $realtime, want.status, rsp_ch.status,
                              " value exp %0d got %0d,",
                              want.read_value, rsp_ch.read_value,
                              " count exp %0d got %0d",
                              want.element_count, rsp_ch.element_count);
                  fault_count++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            positive_only = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            owed_replies.push_back(apply_ring_op(req_ch.opcode, req_ch.value));
      end
      owed_count = owed_replies.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the circular linked ring regression: clock, reset, stimulus and verdict.
// Depends on clr_pkg, clr_if, the ring RTL and clr_ring_checker.
module testbench;
   import clr_pkg::*;

   localparam int POOL_DEPTH   = 64;
   localparam int ITEM_TARGET  = 1800;
   localparam int IDLE_PCT     = 19;
   localparam int MODE_PERIOD  = 450;   // items between mode register changes
   localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 8;     // quiet cycles after the last response
   localparam int CYCLE_LIMIT  = 400000;

   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam value_type VALUE_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset;

   clr_req_if req_ch ();
   clr_rsp_if rsp_ch ();
   clr_csr_if csr_ch ();

   int fault_count;
   int owed_count;
   int items_sent;
   int cycles_run;
   int hold_left;
   bit steady;            // both sides stop idling while set
   bit rsp_hold_request;  // main sequence asks the receiver for a long hold-off
   bit mode;

   circular_linked_ring #(.POOL_DEPTH(POOL_DEPTH)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   clr_ring_checker #(.POOL_DEPTH(POOL_DEPTH)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .fault_count (fault_count),
      .owed_count  (owed_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if the ring stops answering.
   initial begin
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("circular_linked_ring regression: fail");
      $finish;
   end

   // Receiver: drop ready at random, except during the steady stretch, and
   // hold it low for a long stretch when the main sequence asks, so the
   // response register fills and the block backs up into its input.
   initial begin
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Mostly ordinary values, with the signed extremes and the boundary
   // around zero often enough to hit the mode check.
   function automatic value_type pick_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 1;
         2:       return -1;
         3:       return VALUE_MAX;
         4:       return VALUE_MIN;
         default: return value_type'($urandom);
      endcase
   endfunction

   // Offer one item and hold it until the block takes it. Random idle
   // cycles go in front of the item; the payload wanders while valid is low.
   task automatic offer(input opcode_type op, input value_type val);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid  <= 1'b0;
         req_ch.opcode <= opcode_type'($urandom_range(3));
         req_ch.value  <= value_type'($urandom);
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.value  <= val;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Stop offering and wait until every owed response has been taken.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
   endtask

   // Change positive_only only while nothing is in flight.
   task automatic write_mode(input bit m);
      settle();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= m;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      mode = m;
   endtask

   // One random stretch of items. Fill and drain bursts push the ring to
   // full and back to empty; walks move the cursor around a populated ring;
   // churn mixes everything, including removes on an empty ring.
   task automatic run_segment();
      int n;
      int kind;
      opcode_type op;
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2: n = $urandom_range(30, 75);
         3, 4:    n = $urandom_range(20, 70);
         5, 6:    n = $urandom_range(10, 40);
         default: n = $urandom_range(5, 60);
      endcase
      for (int i = 0; i < n; i++) begin
         case (kind)
            0, 1, 2: op = ($urandom_range(9) < 8) ? OP_ADD : OP_READ;
            3, 4:    op = ($urandom_range(9) < 8) ? OP_REMOVE :
                          ($urandom_range(1) ? OP_ADVANCE : OP_READ);
            5, 6:    op = $urandom_range(1) ? OP_ADVANCE : OP_READ;
            default: op = opcode_type'($urandom_range(3));
         endcase
         offer(op, pick_value());
      end
   endtask

   initial begin
      bit held;
      bit paused;
      int next_switch;

      // hold every input at a known value from time zero
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.opcode    <= OP_READ;
      req_ch.value     <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.data      <= 1'b0;
      steady           = 1'b0;
      rsp_hold_request = 1'b0;
      items_sent       = 0;
      mode             = 1'b0;
      held             = 1'b0;
      paused           = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty ring: every operation but add answers empty.
      offer(OP_READ, '0);
      offer(OP_REMOVE, '0);
      offer(OP_ADVANCE, VALUE_MAX);
      // First add links the node to itself; the second becomes predecessor.
      offer(OP_ADD, VALUE_MAX);
      offer(OP_READ, '0);
      offer(OP_ADD, VALUE_MIN);
      offer(OP_ADD, '0);
      offer(OP_ADD, -1);
      offer(OP_READ, '0);
      offer(OP_ADVANCE, '0);
      offer(OP_READ, '0);
      offer(OP_ADVANCE, '0);
      offer(OP_ADVANCE, '0);
      offer(OP_READ, '0);
      // Remove moves the cursor to the successor; the last remove empties it.
      offer(OP_REMOVE, '0);
      offer(OP_READ, '0);
      offer(OP_REMOVE, '0);
      offer(OP_REMOVE, '0);
      offer(OP_REMOVE, '0);
      offer(OP_READ, '0);

      // Positive-only mode: zero and negatives bounce, positives go in.
      write_mode(1'b1);
      offer(OP_ADD, '0);
      offer(OP_ADD, -1);
      offer(OP_ADD, VALUE_MIN);
      offer(OP_ADD, 1);
      offer(OP_ADD, VALUE_MAX);
      offer(OP_READ, '0);

      next_switch = items_sent + MODE_PERIOD;
      while (items_sent < ITEM_TARGET) begin
         steady = (items_sent >= 1200 && items_sent < 1500);
         if (!held && items_sent >= 400) begin
            // receiver backs off while the sender keeps going
            rsp_hold_request = 1'b1;
            held = 1'b1;
         end
         if (!paused && items_sent >= 1000) begin
            settle();
            paused = 1'b1;
         end
         if (items_sent >= next_switch) begin
            write_mode(!mode);
            next_switch += MODE_PERIOD;
         end
         run_segment();
      end
      steady = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && owed_count == 0) begin
         $display("circular_linked_ring regression: pass");
      end else begin
         $display("circular_linked_ring regression: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/clr_pkg.sv
rtl/clr_if.sv
rtl/clr_node_mem.sv
rtl/clr_free_stack.sv
rtl/circular_linked_ring.sv
rtl/clr_port_checker.sv
tb/sv/clr_ring_checker.sv
tb/sv/testbench.sv
